// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fmd_pkg.sv
// ---------------------------------------------------------------------------
// fmd_pkg
// Shared types, constants and helpers for the frame motion detector.
// ---------------------------------------------------------------------------
package fmd_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 13;
  localparam int THR_W      = 8;
  localparam int TALLY_W    = 25;
  localparam int HOLD_W     = 8;
  localparam int QUIET_W    = 9;
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int DIM_CALC_W = 14;  // holds any MAX_DIM up to 8192
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST    = DIM_W'(640);
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST   = DIM_W'(480);
  localparam logic [THR_W-1:0]   DIFF_THRESHOLD_RST = THR_W'(35);
  localparam logic [TALLY_W-1:0] MIN_PIXELS_RST     = TALLY_W'(50);
  localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RST    = HOLD_W'(40);

  localparam logic [COORD_W-1:0] COORD_EMPTY_MIN = {COORD_W{1'b1}};
  localparam logic [TALLY_W-1:0] TALLY_MAX       = {TALLY_W{1'b1}};

  localparam logic [GRAY_SUM_W-1:0] W_BLUE   = GRAY_SUM_W'(1868);
  localparam logic [GRAY_SUM_W-1:0] W_GREEN  = GRAY_SUM_W'(9617);
  localparam logic [GRAY_SUM_W-1:0] W_RED    = GRAY_SUM_W'(4899);
  localparam logic [GRAY_SUM_W-1:0] GRAY_RND = GRAY_SUM_W'(8192);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_DIFF_THRESHOLD = 3'd2,
    REG_MIN_PIXELS     = 3'd3,
    REG_HOLD_FRAMES    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [THR_W-1:0]   diff_threshold;
    logic [TALLY_W-1:0] min_pixels;
    logic [HOLD_W-1:0]  hold_frames;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic moving;
  } pix_class_t;

  typedef struct packed {
    logic               alarm;
    logic [TALLY_W-1:0] moving_count;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;
    logic               active;
    logic               episode_start;
    logic               episode_end;
  } result_t;

  function automatic logic [PIX_W-1:0] abs_diff8(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [PIX_W-1:0] gray_level(input logic [PIX_W-1:0] db,
                                                  input logic [PIX_W-1:0] dg,
                                                  input logic [PIX_W-1:0] dr);
    logic [GRAY_SUM_W-1:0] sum;
    sum = W_BLUE * GRAY_SUM_W'(db) + W_GREEN * GRAY_SUM_W'(dg)
        + W_RED * GRAY_SUM_W'(dr) + GRAY_RND;
    gray_level = sum[GRAY_SHIFT +: PIX_W];
  endfunction

endpackage

// File: rtl/core/fmd_cfg_regs.sv
// ---------------------------------------------------------------------------
// fmd_cfg_regs
// Configuration register file, written through a simple indexed write port.
// ---------------------------------------------------------------------------
module fmd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fmd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width    <= fmd_pkg::FRAME_WIDTH_RST;
      cfg.frame_height   <= fmd_pkg::FRAME_HEIGHT_RST;
      cfg.diff_threshold <= fmd_pkg::DIFF_THRESHOLD_RST;
      cfg.min_pixels     <= fmd_pkg::MIN_PIXELS_RST;
      cfg.hold_frames    <= fmd_pkg::HOLD_FRAMES_RST;
    end else if (cfg_write) begin
      case (fmd_pkg::reg_idx_t'(cfg_index))
        fmd_pkg::REG_FRAME_WIDTH:    cfg.frame_width    <= cfg_data[fmd_pkg::DIM_W-1:0];
        fmd_pkg::REG_FRAME_HEIGHT:   cfg.frame_height   <= cfg_data[fmd_pkg::DIM_W-1:0];
        fmd_pkg::REG_DIFF_THRESHOLD: cfg.diff_threshold <= cfg_data[fmd_pkg::THR_W-1:0];
        fmd_pkg::REG_MIN_PIXELS:     cfg.min_pixels     <= cfg_data[fmd_pkg::TALLY_W-1:0];
        fmd_pkg::REG_HOLD_FRAMES:    cfg.hold_frames    <= cfg_data[fmd_pkg::HOLD_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

endmodule

// File: rtl/core/fmd_pixel_class.sv
// ---------------------------------------------------------------------------
// fmd_pixel_class
// Two-stage pixel classifier: input register, then gray difference and
// threshold into a registered moving flag.
// ---------------------------------------------------------------------------
module fmd_pixel_class (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fmd_pkg::PIX_W-1:0]    cur_blue,
  input  logic [fmd_pkg::PIX_W-1:0]    cur_green,
  input  logic [fmd_pkg::PIX_W-1:0]    cur_red,
  input  logic [fmd_pkg::PIX_W-1:0]    bkg_blue,
  input  logic [fmd_pkg::PIX_W-1:0]    bkg_green,
  input  logic [fmd_pkg::PIX_W-1:0]    bkg_red,
  input  logic [fmd_pkg::THR_W-1:0]    diff_threshold,
  input  logic                         acc_ready,
  output fmd_pkg::pix_class_t          cls
);

  logic                      pix_valid;
  logic [fmd_pkg::PIX_W-1:0] cb, cg, cr, bb, bg, br;
  logic                      pix_ready;
  logic                      cls_ready;
  logic [fmd_pkg::PIX_W-1:0] gray;

  assign cls_ready = !cls.valid || acc_ready;
  assign pix_ready = !pix_valid || cls_ready;
  assign in_ready  = pix_ready;

  assign gray = fmd_pkg::gray_level(fmd_pkg::abs_diff8(cb, bb),
                                    fmd_pkg::abs_diff8(cg, bg),
                                    fmd_pkg::abs_diff8(cr, br));

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pix_ready) begin
      pix_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && in_valid) begin
      cb <= cur_blue;
      cg <= cur_green;
      cr <= cur_red;
      bb <= bkg_blue;
      bg <= bkg_green;
      br <= bkg_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls.valid <= 1'b0;
    end else if (cls_ready) begin
      cls.valid <= pix_valid;
    end
    if (cls_ready && pix_valid) begin
      cls.moving <= (gray > diff_threshold);
    end
  end

endmodule

// File: rtl/core/fmd_frame_acc.sv
// ---------------------------------------------------------------------------
// fmd_frame_acc
// Raster position, moving tally, bounding box, episode tracker and the
// per-frame result register.
// ---------------------------------------------------------------------------
module fmd_frame_acc #(
  parameter int MAX_DIM = fmd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fmd_pkg::cfg_t        cfg,
  input  fmd_pkg::pix_class_t  cls,
  output logic                 acc_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fmd_pkg::result_t     res
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int DW = CW + 1;
  localparam int EW = (CW > fmd_pkg::COORD_W) ? CW : fmd_pkg::COORD_W;
  localparam logic [fmd_pkg::DIM_CALC_W-1:0] MAX_EXT = fmd_pkg::DIM_CALC_W'(MAX_DIM);
  localparam logic [EW-1:0] EDGE_EMPTY_MIN = EW'(fmd_pkg::COORD_EMPTY_MIN);

  logic [CW-1:0]               column, row;
  logic [fmd_pkg::TALLY_W-1:0] pixel_tally;
  logic [EW-1:0]               left_edge, top_edge, right_edge, bottom_edge;
  logic                        movement_active;
  logic [fmd_pkg::QUIET_W-1:0] quiet_frames;

  logic [CW-1:0]               column_next, row_next;
  logic [fmd_pkg::TALLY_W-1:0] tally_next;
  logic [EW-1:0]               left_next, top_next, right_next, bottom_next;
  logic                        active_next;
  logic [fmd_pkg::QUIET_W-1:0] quiet_next;
  logic                        alarm, start_pulse, end_pulse;

  logic [DW-1:0] width_c, height_c;
  logic          col_last, row_last, frame_end, fire;
  logic [EW-1:0] col_e, row_e;

  function automatic logic [DW-1:0] clamp_dim(input logic [fmd_pkg::DIM_W-1:0] v);
    logic [fmd_pkg::DIM_CALC_W-1:0] ve;
    logic [fmd_pkg::DIM_CALC_W-1:0] vc;
    ve = fmd_pkg::DIM_CALC_W'(v);
    if (ve == '0) begin
      vc = fmd_pkg::DIM_CALC_W'(1);
    end else if (ve > MAX_EXT) begin
      vc = MAX_EXT;
    end else begin
      vc = ve;
    end
    clamp_dim = vc[DW-1:0];
  endfunction

  assign width_c  = clamp_dim(cfg.frame_width);
  assign height_c = clamp_dim(cfg.frame_height);

  // a position at or past the limit counts as the last one
  assign col_last  = ((DW'(column) + DW'(1)) >= width_c);
  assign row_last  = ((DW'(row) + DW'(1)) >= height_c);
  assign frame_end = col_last && row_last;

  assign acc_ready = !frame_end || !out_valid || out_ready;
  assign fire      = cls.valid && acc_ready;

  assign col_e = EW'(column);
  assign row_e = EW'(row);

  always_comb begin
    tally_next  = pixel_tally;
    left_next   = left_edge;
    right_next  = right_edge;
    top_next    = top_edge;
    bottom_next = bottom_edge;
    if (cls.moving) begin
      if (pixel_tally != fmd_pkg::TALLY_MAX) tally_next = pixel_tally + fmd_pkg::TALLY_W'(1);
      if (col_e < left_edge)   left_next   = col_e;
      if (col_e > right_edge)  right_next  = col_e;
      if (row_e < top_edge)    top_next    = row_e;
      if (row_e > bottom_edge) bottom_next = row_e;
    end

    column_next = col_last ? '0 : CW'(DW'(column) + DW'(1));
    row_next    = row;
    if (col_last) row_next = row_last ? '0 : CW'(DW'(row) + DW'(1));

    alarm       = (tally_next > cfg.min_pixels);
    active_next = movement_active;
    quiet_next  = quiet_frames;
    start_pulse = 1'b0;
    end_pulse   = 1'b0;
    if (alarm) begin
      if (!movement_active) begin
        active_next = 1'b1;
        start_pulse = 1'b1;
      end
      quiet_next = '0;
    end else if (movement_active) begin
      if (quiet_frames > fmd_pkg::QUIET_W'(cfg.hold_frames)) begin
        active_next = 1'b0;
        end_pulse   = 1'b1;
      end else begin
        quiet_next = quiet_frames + fmd_pkg::QUIET_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column          <= '0;
      row             <= '0;
      pixel_tally     <= '0;
      left_edge       <= EDGE_EMPTY_MIN;
      top_edge        <= EDGE_EMPTY_MIN;
      right_edge      <= '0;
      bottom_edge     <= '0;
      movement_active <= 1'b0;
      quiet_frames    <= '0;
    end else if (fire) begin
      column <= column_next;
      row    <= row_next;
      if (frame_end) begin
        pixel_tally     <= '0;
        left_edge       <= EDGE_EMPTY_MIN;
        top_edge        <= EDGE_EMPTY_MIN;
        right_edge      <= '0;
        bottom_edge     <= '0;
        movement_active <= active_next;
        quiet_frames    <= quiet_next;
      end else begin
        pixel_tally <= tally_next;
        left_edge   <= left_next;
        top_edge    <= top_next;
        right_edge  <= right_next;
        bottom_edge <= bottom_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frame_end) begin
      res.alarm         <= alarm;
      res.moving_count  <= tally_next;
      res.box_min_x     <= left_next[fmd_pkg::COORD_W-1:0];
      res.box_min_y     <= top_next[fmd_pkg::COORD_W-1:0];
      res.box_max_x     <= right_next[fmd_pkg::COORD_W-1:0];
      res.box_max_y     <= bottom_next[fmd_pkg::COORD_W-1:0];
      res.active        <= active_next;
      res.episode_start <= start_pulse;
      res.episode_end   <= end_pulse;
    end
  end

endmodule

// File: rtl/core/frame_motion_detector.sv
// ---------------------------------------------------------------------------
// frame_motion_detector
// Background-subtraction motion detector with bounding box and episode
// tracking; one result item per frame.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per pixel, current and
//   background BGR, in raster order. One pixel per cycle while in_ready is high.
//   Output channel (out_valid/out_ready) gives one item after the last pixel
//   of each frame: alarm, moving count, box and episode flags.
//   The frame's last pixel passes the input, classifier and result registers
//   before the result appears. Throughput: 1 pixel per cycle when
//   not stalled; three-register pipeline (input, classifier, accumulator/result).
//   The user is to write configuration (cfg_write/cfg_index/cfg_data) between items
//   while the block is idle (not enforced). Frame size changes act on the next pixel.
//   Reset: pipeline empty, raster position at the frame start, box empty,
//   no episode, registers at their default values.
//   Stall: while an unread result waits, pixels keep flowing until the next
//   frame's last pixel reaches the accumulator; in_ready then drops until
//   the result is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_motion_detector #(
  parameter int MAX_DIM = fmd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fmd_pkg::PIX_W-1:0]        cur_blue,
  input  logic [fmd_pkg::PIX_W-1:0]        cur_green,
  input  logic [fmd_pkg::PIX_W-1:0]        cur_red,
  input  logic [fmd_pkg::PIX_W-1:0]        bkg_blue,
  input  logic [fmd_pkg::PIX_W-1:0]        bkg_green,
  input  logic [fmd_pkg::PIX_W-1:0]        bkg_red,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             alarm,
  output logic [fmd_pkg::TALLY_W-1:0]      moving_count,
  output logic [fmd_pkg::COORD_W-1:0]      box_min_x,
  output logic [fmd_pkg::COORD_W-1:0]      box_min_y,
  output logic [fmd_pkg::COORD_W-1:0]      box_max_x,
  output logic [fmd_pkg::COORD_W-1:0]      box_max_y,
  output logic                             active,
  output logic                             episode_start,
  output logic                             episode_end,
  input  logic                             cfg_write,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  fmd_pkg::cfg_t       cfg;
  fmd_pkg::pix_class_t cls;
  fmd_pkg::result_t    res;
  logic                acc_ready;

  fmd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fmd_pixel_class u_class (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cur_blue       (cur_blue),
    .cur_green      (cur_green),
    .cur_red        (cur_red),
    .bkg_blue       (bkg_blue),
    .bkg_green      (bkg_green),
    .bkg_red        (bkg_red),
    .diff_threshold (cfg.diff_threshold),
    .acc_ready      (acc_ready),
    .cls            (cls)
  );

  fmd_frame_acc #(
    .MAX_DIM (MAX_DIM)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cls       (cls),
    .acc_ready (acc_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign alarm         = res.alarm;
  assign moving_count  = res.moving_count;
  assign box_min_x     = res.box_min_x;
  assign box_min_y     = res.box_min_y;
  assign box_max_x     = res.box_max_x;
  assign box_max_y     = res.box_max_y;
  assign active        = res.active;
  assign episode_start = res.episode_start;
  assign episode_end   = res.episode_end;

  // empty frame must report the empty box
  `ASSERT_IMP(a_empty_box, out_valid && moving_count == '0,
    box_min_x == fmd_pkg::COORD_EMPTY_MIN && box_min_y == fmd_pkg::COORD_EMPTY_MIN &&
    box_max_x == '0 && box_max_y == '0, "empty frame with non-empty box")
  `ASSERT_IMP(a_start_state, out_valid && episode_start,
    active && alarm && !episode_end, "episode start without alarm or active")
  `ASSERT_IMP(a_end_state, out_valid && episode_end,
    !active && !alarm, "episode end while active or alarmed")
  // input only backs up behind an unread result
  `ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready,
    "input stalled without output back-pressure")

endmodule

// File: tb/motion_report_checker.sv
// ---------------------------------------------------------------------------
// motion_report_checker
// Watches the pixel, result and register ports of the frame motion detector,
// keeps its own copy of the raster, box and episode state, and compares every
// frame report the block hands out against the predicted one.
// ---------------------------------------------------------------------------
module motion_report_checker #(
  parameter int MAX_DIM = fmd_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [fmd_pkg::PIX_W-1:0]      cur_blue,
  input  logic [fmd_pkg::PIX_W-1:0]      cur_green,
  input  logic [fmd_pkg::PIX_W-1:0]      cur_red,
  input  logic [fmd_pkg::PIX_W-1:0]      bkg_blue,
  input  logic [fmd_pkg::PIX_W-1:0]      bkg_green,
  input  logic [fmd_pkg::PIX_W-1:0]      bkg_red,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           alarm,
  input  logic [fmd_pkg::TALLY_W-1:0]    moving_count,
  input  logic [fmd_pkg::COORD_W-1:0]    box_min_x,
  input  logic [fmd_pkg::COORD_W-1:0]    box_min_y,
  input  logic [fmd_pkg::COORD_W-1:0]    box_max_x,
  input  logic [fmd_pkg::COORD_W-1:0]    box_max_y,
  input  logic                           active,
  input  logic                           episode_start,
  input  logic                           episode_end,
  input  logic                           cfg_write,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fmd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding,
  output int                             reports_checked,
  output int                             pixels_seen,
  output int                             episodes_begun
);

  logic [fmd_pkg::DIM_W-1:0]   cfg_width;
  logic [fmd_pkg::DIM_W-1:0]   cfg_height;
  logic [fmd_pkg::THR_W-1:0]   cfg_thresh;
  logic [fmd_pkg::TALLY_W-1:0] cfg_min_moving;
  logic [fmd_pkg::HOLD_W-1:0]  cfg_hold;

  logic [fmd_pkg::COORD_W-1:0] col_pos;
  logic [fmd_pkg::COORD_W-1:0] row_pos;
  logic [fmd_pkg::TALLY_W-1:0] moving_tally;
  logic [fmd_pkg::COORD_W-1:0] lo_x;
  logic [fmd_pkg::COORD_W-1:0] lo_y;
  logic [fmd_pkg::COORD_W-1:0] hi_x;
  logic [fmd_pkg::COORD_W-1:0] hi_y;
  logic                        in_episode;
  logic [fmd_pkg::QUIET_W-1:0] calm_frames;

  fmd_pkg::result_t pending_reports[$];

  // zero acts as one, anything past the array limit as the limit
  function automatic int unsigned clip_dim(input logic [fmd_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned channel_gap(input logic [fmd_pkg::PIX_W-1:0] a,
                                              input logic [fmd_pkg::PIX_W-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  function automatic int unsigned luma_of(input int unsigned db,
                                          input int unsigned dg,
                                          input int unsigned dr);
    return (1868 * db + 9617 * dg + 4899 * dr + 8192) >> 14;
  endfunction

  task automatic restart_frame();
    col_pos      = '0;
    row_pos      = '0;
    moving_tally = '0;
    lo_x         = '1;
    lo_y         = '1;
    hi_x         = '0;
    hi_y         = '0;
  endtask

  task automatic take_register();
    case (fmd_pkg::reg_idx_t'(cfg_index))
      fmd_pkg::REG_FRAME_WIDTH:    cfg_width      = cfg_data[fmd_pkg::DIM_W-1:0];
      fmd_pkg::REG_FRAME_HEIGHT:   cfg_height     = cfg_data[fmd_pkg::DIM_W-1:0];
      fmd_pkg::REG_DIFF_THRESHOLD: cfg_thresh     = cfg_data[fmd_pkg::THR_W-1:0];
      fmd_pkg::REG_MIN_PIXELS:     cfg_min_moving = cfg_data[fmd_pkg::TALLY_W-1:0];
      fmd_pkg::REG_HOLD_FRAMES:    cfg_hold       = cfg_data[fmd_pkg::HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic absorb_pixel();
    int unsigned      gray;
    int unsigned      w;
    int unsigned      h;
    fmd_pkg::result_t rep;
    gray = luma_of(channel_gap(cur_blue, bkg_blue), channel_gap(cur_green, bkg_green),
                   channel_gap(cur_red, bkg_red));
    w = clip_dim(cfg_width);
    h = clip_dim(cfg_height);
    pixels_seen++;
    if (gray > cfg_thresh) begin
      if (moving_tally != fmd_pkg::TALLY_MAX) moving_tally++;
      if (col_pos < lo_x) lo_x = col_pos;
      if (col_pos > hi_x) hi_x = col_pos;
      if (row_pos < lo_y) lo_y = row_pos;
      if (row_pos > hi_y) hi_y = row_pos;
    end
    // a position at or past a shrunken limit is treated as the last one
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = '0;
      if (row_pos + 1 < h) begin
        row_pos++;
      end else begin
        rep.alarm         = moving_tally > cfg_min_moving;
        rep.episode_start = 1'b0;
        rep.episode_end   = 1'b0;
        if (rep.alarm) begin
          if (!in_episode) begin
            in_episode        = 1'b1;
            rep.episode_start = 1'b1;
            episodes_begun++;
          end
          calm_frames = '0;
        end else if (in_episode) begin
          if (calm_frames > cfg_hold) begin
            in_episode      = 1'b0;
            rep.episode_end = 1'b1;
          end else begin
            calm_frames = calm_frames + 1'b1;
          end
        end
        rep.moving_count = moving_tally;
        rep.box_min_x    = lo_x;
        rep.box_min_y    = lo_y;
        rep.box_max_x    = hi_x;
        rep.box_max_y    = hi_y;
        rep.active       = in_episode;
        pending_reports.push_back(rep);
        restart_frame();
      end
    end
  endtask

  task automatic check_report();
    fmd_pkg::result_t want;
    fmd_pkg::result_t got;
    got = {alarm, moving_count, box_min_x, box_min_y, box_max_x, box_max_y,
           active, episode_start, episode_end};
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected frame report: count %0d box (%0d,%0d)-(%0d,%0d)",
                 got.moving_count, got.box_min_x, got.box_min_y, got.box_max_x,
                 got.box_max_y);
    end else begin
      want = pending_reports.pop_front();
      reports_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("Frame report %0d wrong (expected/actual): alarm %0b/%0b",
                 reports_checked, want.alarm, got.alarm);
          $write(" count %0d/%0d min_x %0d/%0d min_y %0d/%0d",
                 want.moving_count, got.moving_count, want.box_min_x, got.box_min_x,
                 want.box_min_y, got.box_min_y);
          $display(" max_x %0d/%0d max_y %0d/%0d active %0b/%0b start %0b/%0b end %0b/%0b",
                   want.box_max_x, got.box_max_x, want.box_max_y, got.box_max_y,
                   want.active, got.active, want.episode_start, got.episode_start,
                   want.episode_end, got.episode_end);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_width       = fmd_pkg::FRAME_WIDTH_RST;
      cfg_height      = fmd_pkg::FRAME_HEIGHT_RST;
      cfg_thresh      = fmd_pkg::DIFF_THRESHOLD_RST;
      cfg_min_moving  = fmd_pkg::MIN_PIXELS_RST;
      cfg_hold        = fmd_pkg::HOLD_FRAMES_RST;
      in_episode      = 1'b0;
      calm_frames     = '0;
      mismatches      = 0;
      reports_checked = 0;
      pixels_seen     = 0;
      episodes_begun  = 0;
      restart_frame();
      pending_reports.delete();
    end else begin
      if (cfg_write) take_register();
      // retire before predicting, so a report can never meet its own frame
      if (out_valid && out_ready) check_report();
      if (in_valid && in_ready) absorb_pixel();
    end
    outstanding <= pending_reports.size();
  end

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives pixel streams through the frame motion detector under a series of
// frame sizes, thresholds and hold settings, with random gaps on both sides,
// and reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module testbench;

  localparam int MAX_DIM = fmd_pkg::MAX_DIM_DEFAULT;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [fmd_pkg::PIX_W-1:0]      cur_blue = '0;
  logic [fmd_pkg::PIX_W-1:0]      cur_green = '0;
  logic [fmd_pkg::PIX_W-1:0]      cur_red = '0;
  logic [fmd_pkg::PIX_W-1:0]      bkg_blue = '0;
  logic [fmd_pkg::PIX_W-1:0]      bkg_green = '0;
  logic [fmd_pkg::PIX_W-1:0]      bkg_red = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           alarm;
  logic [fmd_pkg::TALLY_W-1:0]    moving_count;
  logic [fmd_pkg::COORD_W-1:0]    box_min_x;
  logic [fmd_pkg::COORD_W-1:0]    box_min_y;
  logic [fmd_pkg::COORD_W-1:0]    box_max_x;
  logic [fmd_pkg::COORD_W-1:0]    box_max_y;
  logic                           active;
  logic                           episode_start;
  logic                           episode_end;
  logic                           cfg_write = 1'b0;
  logic [fmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int reports_checked;
  int pixels_seen;
  int episodes_begun;

  logic        burst_mode = 1'b0;
  int unsigned sink_hold = 0;

  frame_motion_detector #(.MAX_DIM(MAX_DIM)) u_top (.*);

  motion_report_checker #(.MAX_DIM(MAX_DIM)) u_checker (.*);

  always #2 clk = ~clk;

  // result side: after each item taken, hold ready low for a random pause (none in burst mode)
  always @(posedge clk) begin : sink_side
    int unsigned k;
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_valid && out_ready) begin
      k = burst_mode ? 0 : $urandom_range(0, 9);
      sink_hold <= k;
      out_ready <= (k == 0);
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= (sink_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [fmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fmd_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [fmd_pkg::DIM_W-1:0] w,
                           input logic [fmd_pkg::DIM_W-1:0] h,
                           input logic [fmd_pkg::THR_W-1:0] thr,
                           input logic [fmd_pkg::TALLY_W-1:0] minp,
                           input logic [fmd_pkg::HOLD_W-1:0] hold,
                           input bit with_spare);
    write_reg(fmd_pkg::REG_FRAME_WIDTH, fmd_pkg::CFG_DATA_W'(w));
    write_reg(fmd_pkg::REG_FRAME_HEIGHT, fmd_pkg::CFG_DATA_W'(h));
    write_reg(fmd_pkg::REG_DIFF_THRESHOLD, fmd_pkg::CFG_DATA_W'(thr));
    write_reg(fmd_pkg::REG_MIN_PIXELS, fmd_pkg::CFG_DATA_W'(minp));
    write_reg(fmd_pkg::REG_HOLD_FRAMES, fmd_pkg::CFG_DATA_W'(hold));
    // unmapped indexes must leave every register alone
    if (with_spare)
      for (int i = int'(fmd_pkg::REG_HOLD_FRAMES) + 1; i < (1 << fmd_pkg::CFG_IDX_W); i++)
        write_reg(fmd_pkg::CFG_IDX_W'(i), {fmd_pkg::CFG_DATA_W{1'b1}});
    cfg_write <= 1'b0;
  endtask

  task automatic push_pixel(input logic [fmd_pkg::PIX_W-1:0] cb,
                            input logic [fmd_pkg::PIX_W-1:0] cg,
                            input logic [fmd_pkg::PIX_W-1:0] cr,
                            input logic [fmd_pkg::PIX_W-1:0] bb,
                            input logic [fmd_pkg::PIX_W-1:0] bg,
                            input logic [fmd_pkg::PIX_W-1:0] br);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cur_blue  <= cb;
    cur_green <= cg;
    cur_red   <= cr;
    bkg_blue  <= bb;
    bkg_green <= bg;
    bkg_red   <= br;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // busy_pct: chance that the background is unrelated to the current pixel;
  // otherwise the two differ by a little sensor noise
  task automatic push_scene_pixel(input int unsigned busy_pct);
    logic [fmd_pkg::PIX_W-1:0] cb, cg, cr, bb, bg, br;
    cb = fmd_pkg::PIX_W'($urandom);
    cg = fmd_pkg::PIX_W'($urandom);
    cr = fmd_pkg::PIX_W'($urandom);
    if ($urandom_range(0, 99) < busy_pct) begin
      bb = fmd_pkg::PIX_W'($urandom);
      bg = fmd_pkg::PIX_W'($urandom);
      br = fmd_pkg::PIX_W'($urandom);
    end else begin
      bb = cb + fmd_pkg::PIX_W'($urandom_range(0, 2)) - fmd_pkg::PIX_W'($urandom_range(0, 2));
      bg = cg + fmd_pkg::PIX_W'($urandom_range(0, 2)) - fmd_pkg::PIX_W'($urandom_range(0, 2));
      br = cr + fmd_pkg::PIX_W'($urandom_range(0, 2)) - fmd_pkg::PIX_W'($urandom_range(0, 2));
    end
    push_pixel(cb, cg, cr, bb, bg, br);
  endtask

  task automatic push_still_pixel();
    logic [fmd_pkg::PIX_W-1:0] v;
    v = fmd_pkg::PIX_W'($urandom);
    push_pixel(v, v, v, v, v, v);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned                 random_pixels;
    int unsigned                 area;
    int unsigned                 frames;
    int unsigned                 busy;
    logic [fmd_pkg::DIM_W-1:0]   w;
    logic [fmd_pkg::DIM_W-1:0]   h;
    logic [fmd_pkg::THR_W-1:0]   thr;
    logic [fmd_pkg::TALLY_W-1:0] minp;
    logic [fmd_pkg::HOLD_W-1:0]  hold;

    random_pixels = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 640x480 raster: these pixels only accumulate
    push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd100, 8'd60, 8'd7, 8'd100, 8'd0, 8'd7);
    push_pixel(8'd9, 8'd0, 8'd200, 8'd9, 8'd61, 8'd200);
    settle();

    // width shrinks under the current column: next pixel closes the frame
    configure(13'd3, 13'd1, 8'd35, 25'd50, 8'd40, 1'b1);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    settle();

    // zero size acts as one pixel per frame; walk an episode through hold 0
    configure(13'd0, 13'd0, 8'd0, 25'd0, 8'd0, 1'b0);
    push_pixel(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    push_pixel(8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd40, 8'd40, 8'd40, 8'd40, 8'd40, 8'd40);
    push_pixel(8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    settle();

    // longest hold: the episode survives 256 quiet frames and ends on the next
    configure(13'd1, 13'd1, 8'd0, 25'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    repeat (258) push_still_pixel();
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    settle();

    // oversize raster clamps; a later shrink to one pixel closes the frame
    configure(13'd8191, 13'd8191, 8'd200, 25'd0, 8'd0, 1'b0);
    for (int p = 0; p < 40; p++)
      if (p == 0 || p == 39)
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
      else
        push_scene_pixel(100);
    settle();
    configure(13'd0, 13'd0, 8'd200, 25'd0, 8'd0, 1'b0);
    push_still_pixel();
    settle();

    while (random_pixels < 600) begin
      case ($urandom_range(0, 9))
        0:       w = 13'd0;
        1, 2:    w = fmd_pkg::DIM_W'($urandom_range(7, 20));
        default: w = fmd_pkg::DIM_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 13'd0;
        1, 2:    h = fmd_pkg::DIM_W'($urandom_range(5, 10));
        default: h = fmd_pkg::DIM_W'($urandom_range(1, 4));
      endcase
      area = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      case ($urandom_range(0, 9))
        0, 1:    thr = 8'd0;
        2:       thr = 8'd255;
        default: thr = fmd_pkg::THR_W'($urandom_range(10, 120));
      endcase
      case ($urandom_range(0, 19))
        0, 1:    minp = '0;
        2:       minp = fmd_pkg::TALLY_MAX;
        3:       minp = fmd_pkg::TALLY_W'($urandom);
        default: minp = fmd_pkg::TALLY_W'($urandom_range(0, area));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    hold = fmd_pkg::HOLD_W'($urandom_range(0, 255));
        2, 3:    hold = fmd_pkg::HOLD_W'($urandom_range(3, 10));
        default: hold = fmd_pkg::HOLD_W'($urandom_range(0, 2));
      endcase
      burst_mode <= ($urandom_range(0, 4) == 0);
      configure(w, h, thr, minp, hold, $urandom_range(0, 9) == 0);

      frames = $urandom_range(1, 6);
      repeat (frames) begin
        case ($urandom_range(0, 4))
          0, 1: busy = 0;
          2:    busy = 15;
          3:    busy = 60;
          default: busy = 100;
        endcase
        repeat (area) push_scene_pixel(busy);
        random_pixels += area;
      end
      // leave a frame half done so the next settings land mid-frame
      if (area > 1 && $urandom_range(0, 2) == 0) begin
        busy = $urandom_range(0, 100);
        frames = $urandom_range(1, area - 1);
        repeat (frames) push_scene_pixel(busy);
        random_pixels += frames;
      end
      settle();
    end

    $display("Checked %0d frame reports over %0d pixels, %0d movement episodes begun,",
             reports_checked, pixels_seen, episodes_begun);
    $display("across zero, small, default and oversize frame settings.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d frame reports still due", outstanding);
    $display("Some tests failed");
    $finish;
  end

endmodule
